// ----- hdl/smq_pkg.sv -----
// shared constants, font tables, pipeline advance struct and sine magnitude function
package smq_pkg;

  localparam int DISPLAY_ROWS        = 6;
  localparam int DISPLAY_COLS        = 5;
  localparam int DEF_MESSAGE_LENGTH  = 11;
  localparam int DEF_SINE_ENTRIES    = 1024;
  localparam int MSG_SLOTS           = 64;

  // p / 6 as (p * 171) >> 10, exact for p below 510
  localparam int DIV6_MUL   = 171;
  localparam int DIV6_SHIFT = 10;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [3:0] {
    G_SPACE = 4'd0,
    G_H     = 4'd1,
    G_I     = 4'd2,
    G_D     = 4'd3,
    G_R     = 4'd4,
    G_A     = 4'd5,
    G_T     = 4'd6,
    G_E     = 4'd7,
    G_S     = 4'd8,
    G_DASH  = 4'd9
  } glyph_t;

  // glyph rows, top row first, bit 4 is the leftmost column
  localparam logic [4:0] FONT [10][6] = '{
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
    '{5'h1E, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    '{5'h0F, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
    '{5'h00, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00}
  };

  // " HIDRATE-SE", remaining slots are blank
  localparam glyph_t MSG [MSG_SLOTS] = '{
    0: G_SPACE, 1: G_H, 2: G_I, 3: G_D, 4: G_R, 5: G_A,
    6: G_T, 7: G_E, 8: G_DASH, 9: G_S, 10: G_E,
    default: G_SPACE
  };

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } smq_adv_t;

  // sine magnitude (0..128) at quarter-wave index k of a table of 2**lg entries
  function automatic logic [7:0] pulse_mag(input int k, input int lg);
    logic [63:0] w;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] m;
    longint      sum;
    w    = 64'(k) << (32 - lg);
    x    = (w * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(64'h4000_0000)) begin
      sum = longint'(64'h4000_0000);
    end
    m = (64'(sum) + 64'd4194304) >> 23;
    return m[7:0];
  endfunction

endpackage

// ----- hdl/scrolling_text_marquee_pixel_top.sv -----
// top level: scrolling text marquee pixel query pipeline
//
// query channel (frame, row, col) in, pixel channel (lit, green, blue) out,
// both with valid/stall; a transaction moves at a clock edge with valid high
// and stall low.
// each query answers whether one led of the 6x5 matrix is lit at that frame
// and its pulsing colour; unlit pixels come out black.
// the pipeline has 5 register stages, and pixel_valid is the valid bit of
// the last one. one query per cycle is taken in steady state, since each
// stage hands its item on in the cycle it takes a new one; only pixel_stall
// holds the input back.
// stages: scroll reciprocal multiply and phase multiply, remainder and sine
// table read, remainder correction and colour scaling, glyph slot split,
// font lookup into the output register.
// every stage holds a valid bit; an empty stage fills even while the output
// is stalled, so query_stall rises only once all five stages hold a pixel.
// synchronous reset empties the pipeline; nothing is lost or repeated under
// stall since a full stage only loads when the one after it moves.
module scrolling_text_marquee_pixel_top import smq_pkg::*; #(
  parameter int MESSAGE_LENGTH = DEF_MESSAGE_LENGTH,
  parameter int SINE_ENTRIES   = DEF_SINE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        query_valid,
  output logic        query_stall,
  input  logic [31:0] frame,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output logic        lit,
  output logic [6:0]  green,
  output logic [7:0]  blue
);

  // message slots beyond the table are blank
  function automatic int MessageLengthClip(input int n);
    return (n > MSG_SLOTS) ? MSG_SLOTS : n;
  endfunction

  localparam int SPAN   = MESSAGE_LENGTH * (DISPLAY_COLS + 1) + DISPLAY_COLS;
  localparam int SPAN_W = $clog2(SPAN + 1);
  localparam int SHIFT  = 31 + SPAN_W;
  localparam int QW     = 32 - SPAN_W;
  localparam int RW     = SPAN_W + 1;
  localparam int PWD    = $clog2(SPAN + DISPLAY_COLS);
  localparam int SW     = PWD - 2;
  localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / 64'(SPAN);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [SW-1:0] MSG_LEN = SW'(MessageLengthClip(MESSAGE_LENGTH));
  localparam logic [2:0] ROW_TOP = 3'(DISPLAY_ROWS - 1);
  localparam logic [2:0] COL_TOP = 3'(DISPLAY_COLS - 1);

  logic [4:0] vld;
  logic [4:0] adv;
  smq_adv_t   padv;

  always_comb begin
    adv[4] = !vld[4] || !pixel_stall;
    for (int i = 3; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign query_stall = !adv[0];
  assign pixel_valid = vld[4];
  assign padv        = '{s1: adv[0], s2: adv[1], s3: adv[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= query_valid;
      end
      for (int i = 1; i < 5; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: quotient estimate of (frame >> 1) / span
  logic [62:0]   rc_prod;
  logic [QW-1:0] s1_q;
  logic [30:0]   s1_half;
  logic [2:0]    s1_col;
  logic [2:0]    s1_row;
  logic          s1_ok;

  assign rc_prod = 63'(frame[31:1]) * 63'(RECIP);

  // stage 2: remainder, below twice the span
  logic [RW-1:0] s2_r;
  logic [2:0]    s2_col;
  logic [2:0]    s2_row;
  logic          s2_ok;

  // stage 3: scroll offset plus column
  logic [RW-1:0]  off;
  logic [PWD-1:0] s3_p;
  logic [2:0]     s3_row;
  logic           s3_ok;

  assign off = (s2_r >= RW'(SPAN)) ? s2_r - RW'(SPAN) : s2_r;

  // stage 4: glyph slot and glyph column
  logic [PWD+7:0] d6;
  logic [SW-1:0]  slot;
  logic [PWD-1:0] s6;
  logic [SW-1:0]  s4_slot;
  logic [2:0]     s4_gc;
  logic [2:0]     s4_row;
  logic           s4_ok;
  logic [6:0]     s4_green;
  logic [7:0]     s4_blue;
  logic [6:0]     p_green;
  logic [7:0]     p_blue;

  assign d6   = (PWD+8)'(s3_p) * (PWD+8)'(DIV6_MUL);
  assign slot = d6[PWD+7:DIV6_SHIFT];
  assign s6   = PWD'({slot, 2'b00}) + PWD'({slot, 1'b0});

  // stage 5: font lookup
  glyph_t     glyph;
  logic [4:0] rbits;
  logic       on;

  assign glyph = MSG[6'(s4_slot)];
  assign rbits = FONT[glyph][ROW_TOP - s4_row];
  assign on    = s4_ok && (s4_slot < MSG_LEN) && (s4_gc <= COL_TOP)
                 && rbits[COL_TOP - s4_gc];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_q    <= rc_prod[62:SHIFT];
      s1_half <= frame[31:1];
      s1_col  <= col;
      s1_row  <= row;
      s1_ok   <= (row <= ROW_TOP) && (col <= COL_TOP);
    end
    if (adv[1]) begin
      s2_r   <= s1_half[RW-1:0] - RW'(s1_q * QW'(SPAN));
      s2_col <= s1_col;
      s2_row <= s1_row;
      s2_ok  <= s1_ok;
    end
    if (adv[2]) begin
      s3_p   <= PWD'(off) + PWD'(s2_col);
      s3_row <= s2_row;
      s3_ok  <= s2_ok;
    end
    if (adv[3]) begin
      s4_slot  <= slot;
      s4_gc    <= 3'(s3_p - s6);
      s4_row   <= s3_row;
      s4_ok    <= s3_ok;
      s4_green <= p_green;
      s4_blue  <= p_blue;
    end
    if (adv[4]) begin
      lit   <= on;
      green <= on ? s4_green : 7'd0;
      blue  <= on ? s4_blue : 8'd0;
    end
  end

  smq_pulse #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_pulse (
    .clk   (clk),
    .adv   (padv),
    .frame (frame),
    .green (p_green),
    .blue  (p_blue)
  );

`ifndef SYNTHESIS
  a_dark: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !lit |-> green == 7'd0 && blue == 8'd0)
    else $error("unlit pixel carries colour");

  a_color: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && lit |-> green >= 7'd30 && blue >= 8'd150)
    else $error("lit pixel below colour floor");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> !query_stall)
    else $error("query stalled with empty first stage");

  a_rem: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> s2_r < RW'(2 * SPAN))
    else $error("scroll remainder estimate out of range");

  a_gc: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> s4_gc <= 3'(DISPLAY_COLS))
    else $error("glyph column out of range");
`endif

endmodule

// ----- hdl/smq_pulse.sv -----
// pulsing colour: phase index, quarter-wave sine lookup, green and blue scaling
module smq_pulse import smq_pkg::*; #(
  parameter int SINE_ENTRIES = DEF_SINE_ENTRIES
) (
  input  logic        clk,
  input  smq_adv_t    adv,
  input  logic [31:0] frame,
  output logic [6:0]  green,
  output logic [7:0]  blue
);

  localparam int LG         = $clog2(SINE_ENTRIES);
  localparam int KW         = LG - 1;
  localparam int QTR        = SINE_ENTRIES / 4;
  localparam int PW         = 8 + LG;
  localparam int PHASE_STEP = (SINE_ENTRIES * 4172 + 512) / 1024;

  logic [7:0] m_rom [QTR+1];

  for (genvar g = 0; g <= QTR; g++) begin : g_rom
    assign m_rom[g] = pulse_mag(g, LG);
  end

  logic [PW-1:0] ph_prod;
  logic [LG-1:0] idx;
  logic [1:0]    quad;
  logic [KW-1:0] k;
  logic [7:0]    m;
  logic          neg;
  logic [8:0]    pulse;
  logic [14:0]   g_prod;
  logic [14:0]   b_prod;

  // only the low bits of frame * step reach the index
  assign ph_prod = frame[PW-1:0] * PW'(PHASE_STEP);
  assign quad    = idx[LG-1:LG-2];
  assign k       = quad[0] ? KW'(QTR) - KW'(idx[LG-3:0]) : KW'(idx[LG-3:0]);
  assign pulse   = neg ? 9'd128 - 9'(m) : 9'd128 + 9'(m);
  assign g_prod  = 15'(pulse) * 15'd40;
  assign b_prod  = 15'(pulse) * 15'd100;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      idx <= ph_prod[PW-1:8];
    end
    if (adv.s2) begin
      m   <= m_rom[k];
      neg <= quad[1];
    end
    if (adv.s3) begin
      green <= 7'd30 + 7'(g_prod[14:8]);
      blue  <= 8'd150 + 8'(b_prod[14:8]);
    end
  end

endmodule

// ----- tb/tb.sv -----
// testbench for the scrolling text marquee pixel query pipeline
`timescale 1ns / 1ps

module tb;
  import smq_pkg::*;

  localparam int unsigned GLYPH_PITCH = DISPLAY_COLS + 1;
  localparam int unsigned BANNER_GLYPHS = 11;
  localparam int unsigned SCROLL_SPAN = BANNER_GLYPHS * GLYPH_PITCH + DISPLAY_COLS;
  localparam string BANNER = " HIDRATE-SE";
  localparam logic [63:0] PHASE_STEP = 64'd4172;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'h4000_0000;
  localparam int RANDOM_QUERIES = 400;

  typedef struct packed {
    logic [31:0] frame;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        hold;
  } query_t;

  typedef struct packed {
    logic       lit;
    logic [6:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        query_valid = 1'b0;
  logic        query_stall;
  logic [31:0] frame = '0;
  logic [2:0]  row = '0;
  logic [2:0]  col = '0;
  logic        pixel_valid;
  logic        pixel_stall = 1'b0;
  logic        lit;
  logic [6:0]  green;
  logic [7:0]  blue;

  query_t query_q[$];
  pixel_t pending_pixels[$];
  query_t next_query;
  pixel_t want;
  logic   query_taken = 1'b0;
  int     send_gap = 0;
  int     stall_left = 0;
  bit     send_calm = 1'b0;
  bit     stall_calm = 1'b0;
  int     mismatches = 0;
  int     queries_taken = 0;
  int     off_grid = 0;
  int     pixels_checked = 0;
  int     lit_seen = 0;

  scrolling_text_marquee_pixel_top dut (
    .clk(clk),
    .rst(rst),
    .query_valid(query_valid),
    .query_stall(query_stall),
    .frame(frame),
    .row(row),
    .col(col),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .lit(lit),
    .green(green),
    .blue(blue)
  );

  always #10 clk = ~clk;

  // five columns of one glyph row, top row first, bit 4 leftmost
  function automatic logic [4:0] font_row(input byte ch, input int unsigned top_row);
    logic [29:0] rows;
    case (ch)
      "H": rows = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      "D": rows = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      "R": rows = {5'h1E, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "A": rows = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
      "T": rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "E": rows = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "S": rows = {5'h0F, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
      "-": rows = {5'h00, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00};
      default: rows = '0;
    endcase
    return rows[29 - 5 * top_row -: 5];
  endfunction

  // pulse level 0..256 at a sine phase index, taylor series in q30
  function automatic logic [8:0] sine_pulse(input logic [9:0] idx);
    logic [63:0] turn;
    logic [63:0] w;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] mag;
    logic [1:0]  quad;
    longint      acc;
    turn = 64'(idx) << 22;
    quad = turn[31:30];
    w = {34'd0, turn[29:0]};
    if (quad[0]) begin
      w = ONE_Q30 - w;
    end
    x = (w * QUARTER_TURN_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(ONE_Q30)) begin
      acc = longint'(ONE_Q30);
    end
    mag = (64'(acc) + 64'd4194304) >> 23;
    return (quad < 2) ? 9'(128 + mag) : 9'(128 - mag);
  endfunction

  function automatic pixel_t predict_pixel(input logic [31:0] f, input logic [2:0] r,
                                           input logic [2:0] c);
    pixel_t      px;
    int unsigned pos;
    int unsigned slot;
    int unsigned gcol;
    logic [4:0]  bits;
    logic [63:0] phase;
    logic [8:0]  pulse;
    px = '0;
    if (r < DISPLAY_ROWS && c < DISPLAY_COLS) begin
      pos = c + (f >> 1) % SCROLL_SPAN;
      slot = pos / GLYPH_PITCH;
      gcol = pos % GLYPH_PITCH;
      // beyond the last glyph and in the gap column stays dark
      if (slot < BANNER_GLYPHS && gcol < DISPLAY_COLS) begin
        // rows are shown upside down
        bits = font_row(BANNER[slot], DISPLAY_ROWS - 1 - r);
        px.lit = bits[DISPLAY_COLS - 1 - gcol];
      end
    end
    if (px.lit) begin
      phase = (64'(f) * PHASE_STEP) >> 8;
      pulse = sine_pulse(phase[9:0]);
      px.green = 7'(30 + ((40 * pulse) >> 8));
      px.blue = 8'(150 + ((100 * pulse) >> 8));
    end
    return px;
  endfunction

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 30) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic add_query(input logic [31:0] f, input logic [2:0] r, input logic [2:0] c,
                           input logic hold);
    query_q.push_back('{frame: f, row: r, col: c, hold: hold});
  endtask

  // query driver
  always @(negedge clk) begin
    if (rst) begin
      query_valid <= 1'b0;
    end else if (query_valid && !query_taken) begin
      // transaction still waiting, payload held
    end else if (send_gap > 0) begin
      query_valid <= 1'b0;
      send_gap--;
    end else if (query_q.size() != 0 && !(query_q[0].hold && pending_pixels.size() != 0)) begin
      next_query = query_q.pop_front();
      frame <= next_query.frame;
      row <= next_query.row;
      col <= next_query.col;
      query_valid <= 1'b1;
      if ($urandom_range(0, 39) == 0) begin
        send_calm = !send_calm;
      end
      send_gap = idle_len(send_calm);
    end else begin
      query_valid <= 1'b0;
    end
  end

  // pixel receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 49) == 0) begin
        stall_calm = !stall_calm;
      end
      if (stall_left > 0) begin
        stall_left--;
        pixel_stall <= 1'b1;
      end else begin
        stall_left = idle_len(stall_calm);
        if (stall_left > 0) begin
          stall_left--;
          pixel_stall <= 1'b1;
        end else begin
          pixel_stall <= 1'b0;
        end
      end
    end
  end

  // monitor: log accepted queries, check each pixel transaction in order
  always @(posedge clk) begin
    if (rst) begin
      query_taken <= 1'b0;
    end else begin
      query_taken <= query_valid && !query_stall;
      if (pixel_valid && !pixel_stall) begin
        pixels_checked++;
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel lit=%0b g=%0d b=%0d with no query pending",
                                    lit, green, blue));
        end else begin
          want = pending_pixels.pop_front();
          if (want.lit) begin
            lit_seen++;
          end
          if (lit !== want.lit) begin
            report_mismatch($sformatf("lit %b, predicted %b", lit, want.lit));
          end
          if (green !== want.green) begin
            report_mismatch($sformatf("green %0d, predicted %0d", green, want.green));
          end
          if (blue !== want.blue) begin
            report_mismatch($sformatf("blue %0d, predicted %0d", blue, want.blue));
          end
        end
      end
      if (query_valid && !query_stall) begin
        pending_pixels.push_back(predict_pixel(frame, row, col));
        queries_taken++;
        if (row >= DISPLAY_ROWS || col >= DISPLAY_COLS) begin
          off_grid++;
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [31:0] f;
    logic [2:0]  r;
    logic [2:0]  c;

    // directed: field extremes, off-grid, gap column, past the end, pulse peak and trough
    add_query(32'd0, 3'd0, 3'd0, 1'b0);
    add_query(32'd0, 3'd5, 3'd4, 1'b0);
    add_query(32'hFFFF_FFFF, 3'd0, 3'd0, 1'b0);
    add_query(32'hFFFF_FFFF, 3'd5, 3'd4, 1'b0);
    add_query(32'hFFFF_FFFE, 3'd4, 3'd3, 1'b0);
    add_query(32'd12, 3'd0, 3'd0, 1'b0);
    add_query(32'd13, 3'd5, 3'd0, 1'b0);
    add_query(32'd12, 3'd3, 3'd4, 1'b0);
    add_query(32'd12, 3'd3, 3'd2, 1'b0);
    add_query(32'd12, 3'd2, 3'd2, 1'b0);
    add_query(32'd12, 3'd6, 3'd0, 1'b0);
    add_query(32'd12, 3'd7, 3'd0, 1'b0);
    add_query(32'd12, 3'd0, 3'd5, 1'b0);
    add_query(32'd12, 3'd0, 3'd7, 1'b0);
    add_query(32'd12, 3'd7, 3'd7, 1'b0);
    add_query(32'd10, 3'd0, 3'd0, 1'b0);
    add_query(32'd22, 3'd0, 3'd0, 1'b0);
    add_query(32'd120, 3'd0, 3'd0, 1'b0);
    add_query(32'd120, 3'd0, 3'd4, 1'b0);
    add_query(32'd132, 3'd0, 3'd4, 1'b0);
    add_query(32'd140, 3'd0, 3'd0, 1'b0);
    add_query(32'd141, 3'd3, 3'd4, 1'b0);
    add_query(32'd16, 3'd3, 3'd0, 1'b0);
    add_query(32'd47, 3'd2, 3'd1, 1'b0);

    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        f = $urandom;
      end else if (pick == 2) begin
        f = $urandom_range(0, 2000);
      end else begin
        f = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      end
      r = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, DISPLAY_ROWS - 1))
                                       : 3'($urandom_range(DISPLAY_ROWS, 7));
      c = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, DISPLAY_COLS - 1))
                                       : 3'($urandom_range(DISPLAY_COLS, 7));
      // drain the pipeline now and then before the next query
      add_query(f, r, c, n == 0 || n == RANDOM_QUERIES / 2 || $urandom_range(0, 99) == 0);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (query_q.size() != 0 || query_valid || pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);

    $display("%0d pixel queries taken, %0d of them off the grid", queries_taken, off_grid);
    $display("%0d pixel results checked, %0d lit, %0d mismatches",
             pixels_checked, lit_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout waiting for pixel transactions");
    $display("simulation failed");
    $finish;
  end

endmodule
